[src/cc20_pkg.sv]
// Shared types, constants and helpers for the ChaCha20 stream cipher block.
// Used by the controller, the datapath, the top level and the testbench.
package cc20_pkg;

    // Configuration port geometry
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_CFG_REGS = 7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0       = 3'd0,
        REG_KEY1       = 3'd1,
        REG_KEY2       = 3'd2,
        REG_KEY3       = 3'd3,
        REG_NONCE_LOW  = 3'd4,
        REG_NONCE_HIGH = 3'd5,
        REG_START_CTR  = 3'd6
    } cfg_reg_t;

    // Block geometry: 16 words, 64 bytes, position counts 0..64
    localparam int NUM_WORDS = 16;
    localparam int POS_W     = 7;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    // Controller to datapath commands
    typedef struct packed {
        logic       load;   // load working state from the block input
        logic       round;  // one add-xor-rotate step on all four lanes
        logic       feed;   // add the block input back in
        logic       copy;   // move finished block into the keystream buffer
        logic       diag;   // diagonal round when set, column round otherwise
        logic [1:0] sub;    // step within the quarter round
    } cc20_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ks_empty;     // every byte of the keystream buffer is used
    } cc20_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

[src/cc20_in_if.sv]
// Byte request channel into the cipher: valid/ready plus data byte and end flag.
// Stand-alone interface, no dependencies.
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in;

    modport source (output valid, output data_byte, output last_in, input ready);
    modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

[src/cc20_out_if.sv]
// Result channel out of the cipher: valid/ready plus cipher byte and end flag.
// Stand-alone interface, no dependencies.
interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

[src/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher top level. A request leaves as a result in the cycle after it
// is taken. A keystream block steps through load, rounds, feed-forward and copy to the
// buffer, one step of four quarter-round lanes per cycle; it runs while the previous block's
// bytes go out, so throughput is one byte a cycle while the buffer holds bytes and results
// are taken. Reset, or any config write to a valid register, restarts at the start counter
// and stalls requests until the buffer is refilled. Uses cc20_pkg, cc20_ctrl, cc20_datapath.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data,
    cc20_in_if.sink                          bytes,
    cc20_out_if.source                       results
);

    cc20_pkg::cc20_cmd_t  cmd;
    cc20_pkg::cc20_stat_t stat;
    logic                 cfg_hit;

    // Writes beyond the register list are ignored
    assign cfg_hit = cfg_wr_en && (cfg_index < cc20_pkg::CFG_IDX_W'(cc20_pkg::NUM_CFG_REGS));

    cc20_ctrl #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_hit),
        .stat    (stat),
        .cmd     (cmd)
    );

    cc20_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_hit   (cfg_hit),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (bytes),
        .results   (results)
    );

`ifndef SYNTHESIS
    // A taken request shows up as a result on the next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes.valid && bytes.ready) |=> results.valid)
        else $error("taken request did not produce a result");

    // The buffer is only refilled once every byte has been used
    a_copy_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy |-> stat.ks_empty)
        else $error("keystream buffer overwritten while in use");

    // A config write leaves the stream waiting for a fresh block
    a_restart_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (stat.ks_empty && !bytes.ready))
        else $error("config write did not restart the stream");
`endif

endmodule

[src/cc20_ctrl.sv]
// Block generation sequencer: load, rounds, feed-forward, hand-off to buffer.
// Depends on cc20_pkg for the command and status structs.
module cc20_ctrl #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  cc20_pkg::cc20_stat_t stat,
    output cc20_pkg::cc20_cmd_t  cmd
);

    localparam int NUM_STEPS = 8 * DOUBLE_ROUNDS;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FEED  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Sequence the block and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sub    = step_reg[1:0];
        cmd.diag   = step_reg[2];
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FEED;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                cmd.copy = stat.ks_empty;
                if (stat.ks_empty)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        // Drop the block in progress on a restart
        if (restart)
        begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[src/cc20_datapath.sv]
// Cipher datapath: config registers, working state with four quarter-round
// lanes, keystream buffer, byte select and output register. Uses cc20_pkg.
module cc20_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cc20_pkg::cc20_cmd_t              cmd,
    output cc20_pkg::cc20_stat_t             stat,
    input  logic                             cfg_hit,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data,
    cc20_in_if.sink                          bytes,
    cc20_out_if.source                       results
);

    logic [63:0] key_reg [4];
    logic [63:0] nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [31:0] start_ctr_reg;
    logic [31:0] ctr_reg;

    logic [31:0] w_reg  [cc20_pkg::NUM_WORDS];
    logic [31:0] ks_reg [cc20_pkg::NUM_WORDS];
    logic [cc20_pkg::POS_W-1:0] pos_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_out_reg;

    logic [31:0] init_w  [cc20_pkg::NUM_WORDS];
    logic [31:0] round_w [cc20_pkg::NUM_WORDS];
    logic [31:0] la [4], lb [4], lc [4], ld [4];
    logic [31:0] na [4], nb [4], nc [4], nd [4];
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;
    logic        accept;

    // Block input words
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_w[i]         = cc20_pkg::SIGMA[i];
            init_w[4 + 2 * i] = key_reg[i][31:0];
            init_w[5 + 2 * i] = key_reg[i][63:32];
        end
        init_w[12] = ctr_reg;
        init_w[13] = nonce_low_reg[31:0];
        init_w[14] = nonce_low_reg[63:32];
        init_w[15] = nonce_high_reg;
    end

    // Gather lanes: columns, or diagonals shifted along each row
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            la[j] = w_reg[j];
            lb[j] = cmd.diag ? w_reg[4 + ((j + 1) % 4)]  : w_reg[4 + j];
            lc[j] = cmd.diag ? w_reg[8 + ((j + 2) % 4)]  : w_reg[8 + j];
            ld[j] = cmd.diag ? w_reg[12 + ((j + 3) % 4)] : w_reg[12 + j];
        end
    end

    // One add-xor-rotate step per lane
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            na[j] = la[j];
            nb[j] = lb[j];
            nc[j] = lc[j];
            nd[j] = ld[j];
            case (cmd.sub)
                2'd0:
                begin
                    na[j] = la[j] + lb[j];
                    nd[j] = cc20_pkg::rotl32(ld[j] ^ na[j], 16);
                end
                2'd1:
                begin
                    nc[j] = lc[j] + ld[j];
                    nb[j] = cc20_pkg::rotl32(lb[j] ^ nc[j], 12);
                end
                2'd2:
                begin
                    na[j] = la[j] + lb[j];
                    nd[j] = cc20_pkg::rotl32(ld[j] ^ na[j], 8);
                end
                default:
                begin
                    nc[j] = lc[j] + ld[j];
                    nb[j] = cc20_pkg::rotl32(lb[j] ^ nc[j], 7);
                end
            endcase
        end
    end

    // Scatter lanes back to their word positions
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            round_w[k]      = na[k];
            round_w[4 + k]  = cmd.diag ? nb[(k + 3) % 4] : nb[k];
            round_w[8 + k]  = cmd.diag ? nc[(k + 2) % 4] : nc[k];
            round_w[12 + k] = cmd.diag ? nd[(k + 1) % 4] : nd[k];
        end
    end

    // Working state
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cc20_pkg::NUM_WORDS; i++)
        begin
            if (cmd.load)
            begin
                w_reg[i] <= init_w[i];
            end
            else if (cmd.round)
            begin
                w_reg[i] <= round_w[i];
            end
            else if (cmd.feed)
            begin
                w_reg[i] <= w_reg[i] + init_w[i];
            end
        end
    end

    // Keystream buffer, filled from the finished block
    always_ff @(posedge clk)
    begin
        if (cmd.copy && !cfg_hit)
        begin
            for (int i = 0; i < cc20_pkg::NUM_WORDS; i++)
            begin
                ks_reg[i] <= w_reg[i];
            end
        end
    end

    assign stat.ks_empty = pos_reg[cc20_pkg::POS_W-1];
    assign accept        = bytes.valid && bytes.ready;
    assign bytes.ready   = !stat.ks_empty && (!out_valid_reg || results.ready);

    // Pick the keystream byte, little-endian within the word
    assign ks_word = ks_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    // Config registers, block counter and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            start_ctr_reg  <= '0;
            ctr_reg        <= '0;
            pos_reg        <= cc20_pkg::POS_W'(64);
        end
        else if (cfg_hit)
        begin
            // Restart the stream from the start counter, taking a new one as it lands
            ctr_reg <= (cfg_index == cc20_pkg::REG_START_CTR) ? cfg_data[31:0]
                                                              : start_ctr_reg;
            pos_reg <= cc20_pkg::POS_W'(64);
            unique case (cfg_index)
                cc20_pkg::REG_KEY0:       key_reg[0]     <= cfg_data;
                cc20_pkg::REG_KEY1:       key_reg[1]     <= cfg_data;
                cc20_pkg::REG_KEY2:       key_reg[2]     <= cfg_data;
                cc20_pkg::REG_KEY3:       key_reg[3]     <= cfg_data;
                cc20_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                cc20_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                cc20_pkg::REG_START_CTR:  start_ctr_reg  <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
        else if (cmd.copy)
        begin
            ctr_reg <= ctr_reg + 32'd1;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= bytes.data_byte ^ ks_byte;
            last_out_reg <= bytes.last_in;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.out_byte = out_byte_reg;
    assign results.last_out = last_out_reg;

endmodule

[tb/sv/chacha20_stream_cipher_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for chacha20_stream_cipher: drives byte requests, predicts the
// RFC 8439 keystream XOR in place, and checks every result byte and end flag.
// Depends on cc20_pkg, cc20_in_if, cc20_out_if and the cipher top level.
module chacha20_stream_cipher_tb;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int BLOCK_BYTES   = 64;
    localparam int MAX_GAP       = 17;
    localparam int LONG_HOLD     = 300;
    localparam logic [cc20_pkg::CFG_IDX_W-1:0] REG_NONE =
        cc20_pkg::CFG_IDX_W'(cc20_pkg::NUM_CFG_REGS);

    // "expand 32-byte k", word 0 in the low lane
    localparam logic [3:0][31:0] EXPAND_K = {
        32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865
    };

    typedef logic [15:0][31:0] cc_words_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } cipher_byte_t;

    logic clk;
    logic rst_n;
    logic                            cfg_wr_en;
    logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data;

    cc20_in_if  byte_ch ();
    cc20_out_if result_ch ();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (byte_ch),
        .results   (result_ch)
    );

    // Cipher state as the block should hold it
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] start_ctr_reg;
    cc_words_t   ks_words;
    logic [31:0] blk_ctr;
    logic [6:0]  ks_pos;

    cipher_byte_t expected_cipher_bytes [$];
    int mismatch_count;
    bit send_idle;
    bit recv_idle;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        logic [63:0] twin;
        twin = {x, x} << n;
        return twin[63:32];
    endfunction

    function automatic cc_words_t quarter(input cc_words_t s, input int a, b, c, d);
        s[a] += s[b]; s[d] = rol(s[d] ^ s[a], 16);
        s[c] += s[d]; s[b] = rol(s[b] ^ s[c], 12);
        s[a] += s[b]; s[d] = rol(s[d] ^ s[a], 8);
        s[c] += s[d]; s[b] = rol(s[b] ^ s[c], 7);
        return s;
    endfunction

    // Full keystream block for one counter value under the current key and nonce
    function automatic cc_words_t keystream_block_for(input logic [31:0] ctr);
        cc_words_t init;
        cc_words_t w;
        for (int i = 0; i < 4; i++)
        begin
            init[i]         = EXPAND_K[i];
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        init[12] = ctr;
        init[13] = nonce_lo_reg[31:0];
        init[14] = nonce_lo_reg[63:32];
        init[15] = nonce_hi_reg;
        w = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            w = quarter(w, 0, 4, 8, 12);
            w = quarter(w, 1, 5, 9, 13);
            w = quarter(w, 2, 6, 10, 14);
            w = quarter(w, 3, 7, 11, 15);
            w = quarter(w, 0, 5, 10, 15);
            w = quarter(w, 1, 6, 11, 12);
            w = quarter(w, 2, 7, 8, 13);
            w = quarter(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init[i];
        return w;
    endfunction

    // Advance the stream by one byte and return the expected result
    function automatic cipher_byte_t predict_cipher_byte(input logic [7:0] data,
                                                         input logic last);
        cipher_byte_t r;
        logic [31:0] word;
        if (ks_pos >= BLOCK_BYTES)
        begin
            ks_words = keystream_block_for(blk_ctr);
            blk_ctr  = blk_ctr + 32'd1;
            ks_pos   = '0;
        end
        word       = ks_words[ks_pos[5:2]];
        r.out_byte = data ^ word[8 * ks_pos[1:0] +: 8];
        r.last_out = last;
        ks_pos     = ks_pos + 7'd1;
        return r;
    endfunction

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: mismatch in %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Write one register; a valid index restarts the stream
    task automatic write_register(input logic [cc20_pkg::CFG_IDX_W-1:0] index,
                                  input logic [63:0] value);
        bit restart;
        restart = 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index) inside
            cc20_pkg::REG_KEY0, cc20_pkg::REG_KEY1,
            cc20_pkg::REG_KEY2, cc20_pkg::REG_KEY3:
                key_reg[index[1:0]] = value;
            cc20_pkg::REG_NONCE_LOW:  nonce_lo_reg  = value;
            cc20_pkg::REG_NONCE_HIGH: nonce_hi_reg  = value[31:0];
            cc20_pkg::REG_START_CTR:  start_ctr_reg = value[31:0];
            default:                  restart = 1'b0;
        endcase
        if (restart)
        begin
            blk_ctr = start_ctr_reg;
            ks_pos  = 7'(BLOCK_BYTES);
        end
    endtask

    // Offer one request after a random gap and record its expected result once taken
    task automatic send_request(input logic [7:0] data, input logic last);
        int gap;
        cipher_byte_t want;
        gap = draw_gap(send_idle);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.last_in   <= last;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        want = predict_cipher_byte(data, last);
        expected_cipher_bytes.push_back(want);
    endtask

    // Drop valid and hold until every outstanding result is back
    task automatic wait_results_done();
        byte_ch.valid <= 1'b0;
        while (expected_cipher_bytes.size() != 0) @(posedge clk);
    endtask

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++)
            send_request(8'($urandom_range(0, 255)),
                         ($urandom_range(0, 15) == 0) || (i == count - 1));
    endtask

    // Reset values: all-zero key, so zero bytes return the raw keystream
    task automatic test_zero_key_keystream();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b0);
        wait_results_done();
    endtask

    // Known-answer setup with every register written, then field extremes
    task automatic test_known_block();
        write_register(cc20_pkg::REG_KEY0,       64'h0706_0504_0302_0100);
        write_register(cc20_pkg::REG_KEY1,       64'h0f0e_0d0c_0b0a_0908);
        write_register(cc20_pkg::REG_KEY2,       64'h1716_1514_1312_1110);
        write_register(cc20_pkg::REG_KEY3,       64'h1f1e_1d1c_1b1a_1918);
        write_register(cc20_pkg::REG_NONCE_LOW,  64'h4a00_0000_0900_0000);
        write_register(cc20_pkg::REG_NONCE_HIGH, 64'hFFFF_FFFF_0000_0000);
        write_register(cc20_pkg::REG_START_CTR,  64'hA5A5_A5A5_0000_0001);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h01, 1'b1);
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b1);
        send_request(8'hFE, 1'b1);
        send_request(8'h55, 1'b0);
        send_request(8'hAA, 1'b1);
        wait_results_done();
    endtask

    // An unused register index must not restart the stream
    task automatic test_ignored_index();
        send_request(8'h3C, 1'b0);
        send_request(8'hC3, 1'b0);
        send_request(8'h00, 1'b1);
        wait_results_done();
        write_register(REG_NONE, {$urandom, $urandom});
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h0F, 1'b1);
        wait_results_done();
    endtask

    // All-ones config: counter starts at its maximum and wraps to zero
    task automatic test_counter_wrap();
        for (int i = 0; i < cc20_pkg::NUM_CFG_REGS; i++)
            write_register(cc20_pkg::CFG_IDX_W'(i), '1);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        send_random_bytes(2 * BLOCK_BYTES + 10);
        wait_results_done();
    endtask

    // Hold off results for a long stretch while requests keep coming
    task automatic test_backpressure();
        send_idle   = 1'b0;
        recv_idle   = 1'b0;
        hold_cycles = LONG_HOLD;
        send_random_bytes(2 * BLOCK_BYTES);
        wait_results_done();
    endtask

    // Phases of random bytes under random configs, with mid-block restarts
    task automatic test_random_stream();
        int kind;
        logic [63:0] fill;
        for (int p = 0; p < 12; p++)
        begin
            kind = $urandom_range(0, 5);
            for (int i = 0; i < cc20_pkg::NUM_CFG_REGS; i++)
            begin
                if (kind == 0)
                    fill = '0;
                else if (kind == 1)
                    fill = '1;
                else if (kind == 2 && i == cc20_pkg::REG_START_CTR)
                    fill = 64'hFFFF_FFFF - $urandom_range(0, 2);
                else
                    fill = {$urandom, $urandom};
                if (kind < 3 || $urandom_range(0, 2) == 0)
                    write_register(cc20_pkg::CFG_IDX_W'(i), fill);
            end
            if ($urandom_range(0, 3) == 0)
                write_register(REG_NONE, {$urandom, $urandom});
            send_idle = $urandom_range(0, 2) != 0;
            recv_idle = $urandom_range(0, 2) != 0;
            send_random_bytes($urandom_range(8, 180));
            wait_results_done();
        end
    endtask

    // Result side: random stalls, optional long hold, check each result in order
    initial
    begin : result_sink
        int stall;
        cipher_byte_t want;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = draw_gap(recv_idle);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
            if (expected_cipher_bytes.size() == 0)
                report_mismatch("unexpected result", result_ch.out_byte, 'x);
            else
            begin
                want = expected_cipher_bytes.pop_front();
                if (result_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", result_ch.out_byte, want.out_byte);
                if (result_ch.last_out !== want.last_out)
                    report_mismatch("last_out", {7'd0, result_ch.last_out},
                                    {7'd0, want.last_out});
            end
        end
    end

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_in   <= 1'b0;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        nonce_lo_reg   = '0;
        nonce_hi_reg   = '0;
        start_ctr_reg  = '0;
        blk_ctr        = '0;
        ks_pos         = 7'(BLOCK_BYTES);
        mismatch_count = 0;
        hold_cycles    = 0;
        send_idle      = 1'b0;
        recv_idle      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_key_keystream();
        test_known_block();
        test_ignored_index();
        test_counter_wrap();
        test_backpressure();
        test_random_stream();

        wait_results_done();
        repeat (4 * DOUBLE_ROUNDS) @(posedge clk);
        if (mismatch_count == 0)
            $display("chacha20_stream_cipher test passed");
        else
            $display("chacha20_stream_cipher test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #1_000_000;
        $display("chacha20_stream_cipher test failed");
        $finish;
    end

endmodule

[chacha20_stream_cipher.f]
src/cc20_pkg.sv
src/cc20_in_if.sv
src/cc20_out_if.sv
src/cc20_ctrl.sv
src/cc20_datapath.sv
src/chacha20_stream_cipher.sv
tb/sv/chacha20_stream_cipher_tb.sv
